// ----- src/vgp_pkg.sv -----
// Shared widths, character codes, line-mode codes and the result record of the VCF genotype parser.
`default_nettype none

package vgp_pkg;

  // Field widths.
  localparam int TEXT_W      = 8;
  localparam int SAMPLES_W   = 21;
  localparam int COUNT_W     = 22;
  localparam int POS_W       = 31;
  localparam int BIDX_W      = 18;
  localparam int CLASS_W     = 2;
  localparam int TAB_W       = 4;
  localparam int MODE_W      = 3;
  localparam int PHASE_W     = 2;
  localparam int PACK_W      = 8;
  localparam int PBC_W       = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 21;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // Largest sample count honoured; larger settings are clamped to it.
  localparam logic [SAMPLES_W-1:0] MAX_SAMPLES = 21'd1048576;

  // Sparse sites carry at most one alternate haplotype per 32 samples.
  localparam int SPARSE_SHIFT = 5;

  // Characters of interest.
  localparam logic [TEXT_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [TEXT_W-1:0] CHAR_DOT  = 8'h2E;
  localparam logic [TEXT_W-1:0] CHAR_HASH = 8'h23;
  localparam logic [TEXT_W-1:0] CHAR_TAB  = 8'h09;
  localparam logic [TEXT_W-1:0] CHAR_NL   = 8'h0A;
  localparam logic [POS_W-1:0]  DIGIT_BASE = 31'd48;

  // Tab count at which the genotype columns begin.
  localparam logic [TAB_W-1:0] FIXED_TABS = 4'd9;
  localparam logic [TAB_W-1:0] POS_COLUMN = 4'd1;

  // Line modes.
  localparam logic [MODE_W-1:0] MODE_START  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HEADER = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIXED  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GENO   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DONE   = 3'd4;

  // Position within one genotype column.
  localparam logic [PHASE_W-1:0] PH_ALLELE1 = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SEP     = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ALLELE2 = 2'd2;
  localparam logic [PHASE_W-1:0] PH_SKIP    = 2'd3;

  // Result kinds and site classes.
  localparam logic KIND_ALLELE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [CLASS_W-1:0] CLASS_MONO_REF = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MONO_ALT = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_SPARSE   = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_DENSE    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_SAMPLES = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_MAC     = 1'd1;

  // One result item.
  typedef struct packed {
    logic                   item_kind;
    logic [PACK_W-1:0]      allele_byte;
    logic [BIDX_W-1:0]      byte_index;
    logic [POS_W-1:0]       site_position;
    logic [COUNT_W-1:0]     alt_total;
    logic [COUNT_W-1:0]     ref_total;
    logic [SAMPLES_W-1:0]   minor_count;
    logic [CLASS_W-1:0]     site_class;
    logic                   passes_filter;
    logic                   last;
  } result_t;

endpackage

`default_nettype wire

// ----- src/vgp_if.sv -----
// Channel interfaces of the VCF genotype parser: text input, results and configuration writes.
`default_nettype none

interface vgp_text_if;
  import vgp_pkg::*;
  logic              valid;
  logic              ready;
  logic [TEXT_W-1:0] text_byte;
  logic              end_of_input;

  modport source (output valid, output text_byte, output end_of_input, input ready);
  modport sink (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface vgp_result_if;
  import vgp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 item_kind;
  logic [PACK_W-1:0]    allele_byte;
  logic [BIDX_W-1:0]    byte_index;
  logic [POS_W-1:0]     site_position;
  logic [COUNT_W-1:0]   alt_total;
  logic [COUNT_W-1:0]   ref_total;
  logic [SAMPLES_W-1:0] minor_count;
  logic [CLASS_W-1:0]   site_class;
  logic                 passes_filter;
  logic                 last;

  modport source (output valid, output item_kind, output allele_byte, output byte_index,
                  output site_position, output alt_total, output ref_total,
                  output minor_count, output site_class, output passes_filter,
                  output last, input ready);
  modport sink (input valid, input item_kind, input allele_byte, input byte_index,
                input site_position, input alt_total, input ref_total,
                input minor_count, input site_class, input passes_filter,
                input last, output ready);
endinterface

interface vgp_cfg_if;
  import vgp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/vcf_genotype_line_parser_unit.sv -----
// Top level of the VCF genotype parser: line state machine, allele packer and result queue.
//
// Usage. VCF text enters one byte per request on the text channel; end_of_input
// marks the end of the file and acts as a final newline. Header lines ('#') and
// empty lines are skipped. On a data line the POS column is parsed and, after the
// ninth tab, two alleles per sample are packed eight to a byte. Each full byte
// leaves as an allele request; at end of line any partial byte and then a site
// summary follow. The configuration channel sets num_samples and min_mac; it is
// always ready and should be written only while no results are outstanding.
// Throughput is one text byte per cycle while the queue has room. A result appears
// on the result channel the cycle after its byte is taken if the queue was empty.
// An end of line that yields two results queues both at once. Results wait in a
// four-entry queue; the text channel is ready while at least two entries are free,
// so once three results wait on a stalled receiver, input is held and nothing is lost.
// Reset (synchronous, active high) empties the queue, returns the line state to
// line start and sets num_samples to 1 and min_mac to 0.
`default_nettype none

module vcf_genotype_line_parser_unit (
  input  logic         clk,
  input  logic         rst,
  vgp_text_if.sink     text,
  vgp_result_if.source result,
  vgp_cfg_if.sink      cfg
);
  import vgp_pkg::*;

  // Configuration registers, kept in the form the datapath uses.
  logic [SAMPLES_W-1:0] eff_samples;
  logic [COUNT_W-1:0]   two_samples;
  logic [SAMPLES_W-1:0] sparse_limit;
  logic                 eff_zero;
  logic [SAMPLES_W-1:0] min_mac;
  logic [SAMPLES_W-1:0] cfg_clamped;

  // Line state.
  logic [MODE_W-1:0]    mode, mode_next;
  logic [TAB_W-1:0]     tab_seen, tab_seen_next;
  logic [POS_W-1:0]     position, position_next;
  logic [SAMPLES_W-1:0] sample_index, sample_index_next;
  logic [PHASE_W-1:0]   phase, phase_next;
  logic [COUNT_W-1:0]   alt_accum, alt_accum_next;
  logic [PACK_W-1:0]    pack_reg, pack_reg_next;
  logic [PBC_W-1:0]     pack_count, pack_count_next;
  logic [BIDX_W-1:0]    byte_count, byte_count_next;

  // Per-byte decode.
  logic                 in_fire;
  logic                 eol;
  logic                 is_tab;
  logic                 allele_bit;
  logic [PACK_W-1:0]    pack_set;
  logic                 pack_full;
  logic [POS_W-1:0]     position_step;
  logic [TAB_W-1:0]     tab_inc;
  logic [COUNT_W-1:0]   alt_inc;
  logic [SAMPLES_W:0]   sample_inc;

  // Summary arithmetic.
  logic [COUNT_W:0]     ref_wide;
  logic                 ref_borrow;
  logic [COUNT_W-1:0]   ref_val;
  logic [COUNT_W-1:0]   minor_wide;
  logic [CLASS_W-1:0]   class_val;

  // Results produced by the current request.
  result_t              allele_entry;
  result_t              flush_entry;
  result_t              summary_entry;
  result_t              res0, res1;
  logic [1:0]           n_push;

  // Result queue.
  result_t                 fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0]   fifo_count;
  logic                    pop;
  result_t                 head;

  // Configuration writes; the channel never stalls.
  assign cfg.ready   = 1'b1;
  assign cfg_clamped = (cfg.data > MAX_SAMPLES) ? MAX_SAMPLES : cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_samples  <= SAMPLES_W'(1);
      two_samples  <= COUNT_W'(2);
      sparse_limit <= '0;
      eff_zero     <= 1'b0;
      min_mac      <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_NUM_SAMPLES) begin
        eff_samples  <= cfg_clamped;
        two_samples  <= {cfg_clamped, 1'b0};
        sparse_limit <= cfg_clamped >> SPARSE_SHIFT;
        eff_zero     <= (cfg_clamped == '0);
      end else if (cfg.index == CFG_MIN_MAC) begin
        min_mac <= cfg.data;
      end
    end
  end

  // Byte decode shared by all modes.
  assign in_fire    = text.valid & text.ready;
  assign eol        = text.end_of_input | (text.text_byte == CHAR_NL);
  assign is_tab     = (text.text_byte == CHAR_TAB);
  assign allele_bit = (text.text_byte != CHAR_ZERO) && (text.text_byte != CHAR_DOT);
  assign pack_set   = pack_reg | (PACK_W'(allele_bit) << pack_count);
  assign pack_full  = (pack_count == PBC_W'(PACK_W - 1));
  assign tab_inc    = tab_seen + TAB_W'(1);
  assign alt_inc    = alt_accum + COUNT_W'(allele_bit);
  assign sample_inc = {1'b0, sample_index} + (SAMPLES_W + 1)'(1);

  // POS accumulates as pos * 10 + (byte - '0'), wrapping at 31 bits.
  assign position_step = {position[POS_W-4:0], 3'b000} + {position[POS_W-2:0], 1'b0}
                       + POS_W'(text.text_byte) - DIGIT_BASE;

  // Summary figures; a borrow means more alternates than haplotypes, so the
  // true reference count is treated as larger than the alternate count.
  assign ref_wide   = {1'b0, two_samples} - {1'b0, alt_accum};
  assign ref_borrow = ref_wide[COUNT_W];
  assign ref_val    = ref_wide[COUNT_W-1:0];
  assign minor_wide = (!ref_borrow && (ref_val < alt_accum)) ? ref_val : alt_accum;

  always_comb begin
    if (alt_accum == '0) begin
      class_val = CLASS_MONO_REF;
    end else if (ref_wide == '0) begin
      class_val = CLASS_MONO_ALT;
    end else if (alt_accum <= COUNT_W'(sparse_limit)) begin
      class_val = CLASS_SPARSE;
    end else begin
      class_val = CLASS_DENSE;
    end
  end

  // Candidate result records.
  always_comb begin
    allele_entry             = '0;
    allele_entry.item_kind   = KIND_ALLELE;
    allele_entry.allele_byte = pack_set;
    allele_entry.byte_index  = byte_count;
    allele_entry.last        = 1'b1;

    flush_entry             = '0;
    flush_entry.item_kind   = KIND_ALLELE;
    flush_entry.allele_byte = pack_reg;
    flush_entry.byte_index  = byte_count;

    summary_entry               = '0;
    summary_entry.item_kind     = KIND_SUMMARY;
    summary_entry.site_position = position;
    summary_entry.alt_total     = alt_accum;
    summary_entry.ref_total     = ref_val;
    summary_entry.minor_count   = minor_wide[SAMPLES_W-1:0];
    summary_entry.site_class    = class_val;
    summary_entry.passes_filter = (minor_wide >= COUNT_W'(min_mac));
    summary_entry.last          = 1'b1;
  end

  // Line state machine: next state and results for the request in hand.
  always_comb begin
    logic take_fixed;
    logic take_allele;

    take_fixed        = 1'b0;
    take_allele       = 1'b0;
    mode_next         = mode;
    tab_seen_next     = tab_seen;
    position_next     = position;
    sample_index_next = sample_index;
    phase_next        = phase;
    alt_accum_next    = alt_accum;
    pack_reg_next     = pack_reg;
    pack_count_next   = pack_count;
    byte_count_next   = byte_count;
    res0              = summary_entry;
    res1              = summary_entry;
    n_push            = 2'd0;

    if (in_fire) begin
      if (eol) begin
        // End of line: clear the line; in genotype columns also flush a partial byte and report the site.
        if ((mode == MODE_GENO) || (mode == MODE_DONE)) begin
          if (pack_count != '0) begin
            res0   = flush_entry;
            n_push = 2'd2;
          end else begin
            n_push = 2'd1;
          end
        end
        mode_next         = MODE_START;
        tab_seen_next     = '0;
        position_next     = '0;
        sample_index_next = '0;
        phase_next        = PH_ALLELE1;
        alt_accum_next    = '0;
        pack_reg_next     = '0;
        pack_count_next   = '0;
        byte_count_next   = '0;
      end else begin
        case (mode)
          MODE_START: begin
            if (text.text_byte == CHAR_HASH) begin
              mode_next = MODE_HEADER;
            end else begin
              mode_next  = MODE_FIXED;
              take_fixed = 1'b1;
            end
          end
          MODE_FIXED: begin
            take_fixed = 1'b1;
          end
          MODE_GENO: begin
            case (phase)
              PH_ALLELE1: begin
                take_allele = 1'b1;
                phase_next  = PH_SEP;
              end
              PH_SEP: begin
                phase_next = PH_ALLELE2;
              end
              PH_ALLELE2: begin
                take_allele       = 1'b1;
                sample_index_next = sample_inc[SAMPLES_W-1:0];
                if (sample_inc >= {1'b0, eff_samples}) begin
                  mode_next = MODE_DONE;
                end else begin
                  phase_next = is_tab ? PH_ALLELE1 : PH_SKIP;
                end
              end
              default: begin
                if (is_tab) begin
                  phase_next = PH_ALLELE1;
                end
              end
            endcase
          end
          default: begin
          end
        endcase
      end
    end

    // Fixed columns: count tabs and parse POS.
    if (take_fixed) begin
      if (is_tab) begin
        if (tab_inc >= FIXED_TABS) begin
          tab_seen_next = FIXED_TABS;
          mode_next     = eff_zero ? MODE_DONE : MODE_GENO;
          phase_next    = PH_ALLELE1;
        end else begin
          tab_seen_next = tab_inc;
        end
      end else if (tab_seen == POS_COLUMN) begin
        position_next = position_step;
      end
    end

    // One allele into the packer; a full byte leaves at once.
    if (take_allele) begin
      alt_accum_next  = alt_inc;
      pack_count_next = pack_count + PBC_W'(1);
      if (pack_full) begin
        res0            = allele_entry;
        n_push          = 2'd1;
        pack_reg_next   = '0;
        byte_count_next = byte_count + BIDX_W'(1);
      end else begin
        pack_reg_next = pack_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_START;
      tab_seen     <= '0;
      position     <= '0;
      sample_index <= '0;
      phase        <= PH_ALLELE1;
      alt_accum    <= '0;
      pack_reg     <= '0;
      pack_count   <= '0;
      byte_count   <= '0;
    end else begin
      mode         <= mode_next;
      tab_seen     <= tab_seen_next;
      position     <= position_next;
      sample_index <= sample_index_next;
      phase        <= phase_next;
      alt_accum    <= alt_accum_next;
      pack_reg     <= pack_reg_next;
      pack_count   <= pack_count_next;
      byte_count   <= byte_count_next;
    end
  end

  // Result queue: up to two entries in, one out per cycle.
  assign pop        = result.valid & result.ready;
  assign text.ready = (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign head       = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_mem[wr_ptr + FIFO_PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FIFO_PTR_W'(n_push);
      rd_ptr     <= rd_ptr + FIFO_PTR_W'(pop);
      fifo_count <= fifo_count + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
    end
  end

  // Output drive from the head of the queue.
  assign result.valid         = (fifo_count != '0);
  assign result.item_kind     = head.item_kind;
  assign result.allele_byte   = head.allele_byte;
  assign result.byte_index    = head.byte_index;
  assign result.site_position = head.site_position;
  assign result.alt_total     = head.alt_total;
  assign result.ref_total     = head.ref_total;
  assign result.minor_count   = head.minor_count;
  assign result.site_class    = head.site_class;
  assign result.passes_filter = head.passes_filter;
  assign result.last          = head.last;

  // The queue never overfills.
  assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // An end of line always returns the line to its start.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && eol) |=> (mode == MODE_START) && (pack_count == '0) && (alt_accum == '0))
    else $error("line state not cleared after end of line");

  // Outside the genotype columns nothing is packed or counted.
  assert property (@(posedge clk) disable iff (rst)
    ((mode != MODE_GENO) && (mode != MODE_DONE)) |-> (pack_count == '0) && (byte_count == '0))
    else $error("allele state outside genotype columns");

  // The tab count stops at the first genotype column.
  assert property (@(posedge clk) disable iff (rst)
    tab_seen <= FIXED_TABS)
    else $error("tab count ran past the fixed columns");

endmodule

`default_nettype wire
